// ===== rtl/chwd_pkg.sv =====
// package for the capped histogram weighted draw core
// holds sizes, operation and status codes, and the shared structs
// no dependencies
`default_nettype none

package chwd_pkg;

  localparam int NUM_BINS   = 64;
  localparam int MAX_COPIES = 4;

  localparam int KIND_W = 2;
  localparam int IDX_W  = 6;
  localparam int RND_W  = 31;
  localparam int CNT_W  = 3;
  localparam int STAT_W = 3;
  localparam int TOT_W  = 9;
  localparam int STEP_W = $clog2(RND_W);

  localparam logic [KIND_W-1:0] KIND_FILL   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_ADD    = 2'd1;
  localparam logic [KIND_W-1:0] KIND_REMOVE = 2'd2;
  localparam logic [KIND_W-1:0] KIND_DRAW   = 2'd3;

  localparam logic [STAT_W-1:0] STAT_OK    = 3'd0;
  localparam logic [STAT_W-1:0] STAT_RANGE = 3'd1;
  localparam logic [STAT_W-1:0] STAT_FULL  = 3'd2;
  localparam logic [STAT_W-1:0] STAT_EMPTY = 3'd3;
  localparam logic [STAT_W-1:0] STAT_NONE  = 3'd4;

  localparam logic [STAT_W-1:0] ADDR_FILL_COUNT = 3'd0;

  typedef struct packed {
    logic              start;
    logic [RND_W-1:0]  dividend;
    logic [TOT_W-1:0]  divisor;
  } mod_req_t;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [IDX_W-1:0]  idx;
    logic [CNT_W-1:0]  cnt;
    logic [TOT_W-1:0]  total;
    logic              wr;
  } res_t;

endpackage

`default_nettype wire

// ===== rtl/capped_histogram_weighted_draw_core.sv =====
// top level of the capped histogram weighted draw core
// sequencer, apb register, total register and output word stage
// uses chwd_pkg, chwd_bin_ram and chwd_mod_unit
`default_nettype none

// operation: add and remove read their bin, then write it back with the result word;
//   an accepted fill sweeps every bin, a refused one reports bin 0; a draw on an empty
//   histogram goes straight to its result, any other draw runs a 31-step remainder, then
//   a walk reading one bin per cycle from the bin store, over up to 64 bins
// throughput: one word at a time; the next word is taken once the previous
//   result sits in the output register, even while it waits to be taken
// reset: synchronous; after reset a clearing pass over all 64 bins zeroes the
//   bin store, during which no input word is taken (register writes still are)

module capped_histogram_weighted_draw_core (
  input  wire logic        clk,
  input  wire logic        rst,
  // apb register port
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready,
  // input words
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic [chwd_pkg::KIND_W-1:0]    kind,
  input  wire logic [chwd_pkg::IDX_W-1:0]     bin_index,
  input  wire logic [chwd_pkg::RND_W-1:0]     random_value,
  // result words
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic      [chwd_pkg::STAT_W-1:0]    status,
  output logic      [chwd_pkg::IDX_W-1:0]     result_index,
  output logic      [chwd_pkg::CNT_W-1:0]     bin_count,
  output logic      [chwd_pkg::TOT_W-1:0]     total_count
);

  // sequencer states
  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SWEEP = 3'd1;  // fill or post-reset clear
  localparam logic [2:0] S_READ  = 3'd2;  // bin read data is back
  localparam logic [2:0] S_MOD   = 3'd3;  // waiting on the remainder unit
  localparam logic [2:0] S_WALK  = 3'd4;  // pipelined walk over the bins
  localparam logic [2:0] S_FIN   = 3'd5;  // write back and hand over result

  logic [2:0]                     state;
  logic [chwd_pkg::CNT_W-1:0]     fill_cfg;
  logic [chwd_pkg::TOT_W-1:0]     total;
  logic [chwd_pkg::KIND_W-1:0]    op_kind;
  logic [chwd_pkg::IDX_W-1:0]     op_idx;
  logic [chwd_pkg::IDX_W-1:0]     sweep_idx;
  logic [chwd_pkg::CNT_W-1:0]     sweep_val;
  logic                           sweep_fill;
  logic [chwd_pkg::IDX_W-1:0]     walk_addr;
  logic [chwd_pkg::IDX_W-1:0]     chk_idx;
  logic                           chk_valid;
  logic [chwd_pkg::TOT_W-1:0]     walk_r;
  chwd_pkg::res_t                 res;

  logic                           in_accept;
  logic                           fin_go;
  logic                           cfg_write;
  logic                           fill_bad;
  logic                           idx_bad;

  logic                           ram_we;
  logic [chwd_pkg::IDX_W-1:0]     ram_waddr;
  logic [chwd_pkg::CNT_W-1:0]     ram_wdata;
  logic [chwd_pkg::IDX_W-1:0]     ram_raddr;
  logic [chwd_pkg::CNT_W-1:0]     ram_rdata;

  chwd_pkg::mod_req_t             mod_req;
  logic                           mod_done;
  logic [chwd_pkg::TOT_W-1:0]     mod_rem;

  // ---------------------------------------------------------------------------
  // register port: one register, fill_count, at word 0
  // ---------------------------------------------------------------------------
  // word select bit of the fill register's byte address
  localparam logic ADDR_FILL_SEL = chwd_pkg::ADDR_FILL_COUNT[2];

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready &&
                     (paddr[2] == ADDR_FILL_SEL);

  always_comb begin
    if (paddr[2] == ADDR_FILL_SEL) begin
      prdata = {{(32 - chwd_pkg::CNT_W){1'b0}}, fill_cfg};
    end else begin
      prdata = '0;
    end
  end

  // ---------------------------------------------------------------------------
  // input side decode
  // ---------------------------------------------------------------------------
  assign in_ready  = (state == S_IDLE);
  assign in_accept = in_valid && in_ready;
  assign fill_bad  = (fill_cfg > chwd_pkg::CNT_W'(chwd_pkg::MAX_COPIES));
  // never true while the index field covers exactly NUM_BINS bins
  assign idx_bad   = ({1'b0, bin_index} >= (chwd_pkg::IDX_W + 1)'(chwd_pkg::NUM_BINS));

  // result stage is free when the output register is empty or being emptied
  assign fin_go = (state == S_FIN) && (!out_valid || out_ready);

  // remainder unit starts straight from the accepted word
  assign mod_req.start    = in_accept && (kind == chwd_pkg::KIND_DRAW) && (total != '0);
  assign mod_req.dividend = random_value;
  assign mod_req.divisor  = total;

  // ---------------------------------------------------------------------------
  // bin store ports
  // ---------------------------------------------------------------------------
  always_comb begin
    case (state)
      S_IDLE:  ram_raddr = (kind == chwd_pkg::KIND_FILL) ? '0 : bin_index;
      S_WALK:  ram_raddr = walk_addr;
      default: ram_raddr = '0;
    endcase
  end

  always_comb begin
    if (state == S_SWEEP) begin
      ram_we    = 1'b1;
      ram_waddr = sweep_idx;
      ram_wdata = sweep_val;
    end else begin
      ram_we    = fin_go && res.wr;
      ram_waddr = res.idx;
      ram_wdata = res.cnt;
    end
  end

  chwd_bin_ram u_bin_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  chwd_mod_unit u_mod_unit (
    .clk  (clk),
    .rst  (rst),
    .req  (mod_req),
    .done (mod_done),
    .rem  (mod_rem)
  );

  // ---------------------------------------------------------------------------
  // sequencer
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_SWEEP;   // clearing pass
      sweep_idx  <= '0;
      sweep_val  <= '0;
      sweep_fill <= 1'b0;
      fill_cfg   <= '0;
      total      <= '0;
      chk_valid  <= 1'b0;
    end else begin
      if (cfg_write) begin
        fill_cfg <= pwdata[chwd_pkg::CNT_W-1:0];
      end

      case (state)
        S_IDLE: begin
          if (in_accept) begin
            op_kind <= kind;
            op_idx  <= bin_index;
            case (kind)
              chwd_pkg::KIND_FILL: begin
                if (fill_bad) begin
                  state <= S_READ;   // report the untouched count of bin 0
                end else begin
                  state      <= S_SWEEP;
                  sweep_idx  <= '0;
                  sweep_val  <= fill_cfg;
                  sweep_fill <= 1'b1;
                end
              end
              chwd_pkg::KIND_ADD, chwd_pkg::KIND_REMOVE: begin
                if (idx_bad) begin
                  res.status <= chwd_pkg::STAT_RANGE;
                  res.idx    <= bin_index;
                  res.cnt    <= '0;
                  res.total  <= total;
                  res.wr     <= 1'b0;
                  state      <= S_FIN;
                end else begin
                  state <= S_READ;
                end
              end
              default: begin
                if (total == '0) begin
                  res.status <= chwd_pkg::STAT_NONE;
                  res.idx    <= '0;
                  res.cnt    <= '0;
                  res.total  <= total;
                  res.wr     <= 1'b0;
                  state      <= S_FIN;
                end else begin
                  state <= S_MOD;
                end
              end
            endcase
          end
        end

        S_SWEEP: begin
          sweep_idx <= sweep_idx + 1'b1;
          if (sweep_idx == chwd_pkg::IDX_W'(chwd_pkg::NUM_BINS - 1)) begin
            if (sweep_fill) begin
              total      <= chwd_pkg::TOT_W'(fill_cfg) *
                            chwd_pkg::TOT_W'(chwd_pkg::NUM_BINS);
              res.status <= chwd_pkg::STAT_OK;
              res.idx    <= '0;
              res.cnt    <= sweep_val;
              res.total  <= chwd_pkg::TOT_W'(sweep_val) *
                            chwd_pkg::TOT_W'(chwd_pkg::NUM_BINS);
              res.wr     <= 1'b0;
              state      <= S_FIN;
            end else begin
              state <= S_IDLE;
            end
          end
        end

        S_READ: begin
          // a refused fill reports bin 0, add and remove their own bin
          res.idx <= (op_kind == chwd_pkg::KIND_FILL) ? '0 : op_idx;
          case (op_kind)
            chwd_pkg::KIND_FILL: begin
              res.status <= chwd_pkg::STAT_FULL;
              res.cnt    <= ram_rdata;
              res.total  <= total;
              res.wr     <= 1'b0;
            end
            chwd_pkg::KIND_ADD: begin
              if (ram_rdata >= chwd_pkg::CNT_W'(chwd_pkg::MAX_COPIES)) begin
                res.status <= chwd_pkg::STAT_FULL;
                res.cnt    <= ram_rdata;
                res.total  <= total;
                res.wr     <= 1'b0;
              end else begin
                res.status <= chwd_pkg::STAT_OK;
                res.cnt    <= ram_rdata + 1'b1;
                res.total  <= total + 1'b1;
                res.wr     <= 1'b1;
              end
            end
            default: begin
              if (ram_rdata == '0) begin
                res.status <= chwd_pkg::STAT_EMPTY;
                res.cnt    <= ram_rdata;
                res.total  <= total;
                res.wr     <= 1'b0;
              end else begin
                res.status <= chwd_pkg::STAT_OK;
                res.cnt    <= ram_rdata - 1'b1;
                res.total  <= total - 1'b1;
                res.wr     <= 1'b1;
              end
            end
          endcase
          state <= S_FIN;
        end

        S_MOD: begin
          if (mod_done) begin
            walk_r    <= mod_rem + 1'b1;
            walk_addr <= '0;
            chk_valid <= 1'b0;
            state     <= S_WALK;
          end
        end

        S_WALK: begin
          // address goes out the cycle before the compare on its data
          walk_addr <= walk_addr + 1'b1;
          chk_idx   <= walk_addr;
          if (chk_valid && (walk_r <= chwd_pkg::TOT_W'(ram_rdata))) begin
            res.status <= chwd_pkg::STAT_OK;
            res.idx    <= chk_idx;
            res.cnt    <= ram_rdata - 1'b1;
            res.total  <= total - 1'b1;
            res.wr     <= 1'b1;
            chk_valid  <= 1'b0;
            state      <= S_FIN;
          end else begin
            chk_valid <= 1'b1;
            if (chk_valid) begin
              walk_r <= walk_r - chwd_pkg::TOT_W'(ram_rdata);
            end
          end
        end

        S_FIN: begin
          if (fin_go) begin
            total <= res.total;
            state <= S_IDLE;
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // output word register
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fin_go) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fin_go) begin
      status       <= res.status;
      result_index <= res.idx;
      bin_count    <= res.cnt;
      total_count  <= res.total;
    end
  end

  // ---------------------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------------------
  a_total_cap: assert property (@(posedge clk) disable iff (rst)
    total <= chwd_pkg::TOT_W'(chwd_pkg::NUM_BINS * chwd_pkg::MAX_COPIES))
    else $error("total above capacity");

  a_mod_done_state: assert property (@(posedge clk) disable iff (rst)
    mod_done |-> (state == S_MOD))
    else $error("remainder finished outside its wait state");

  a_ram_write_state: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> ((state == S_SWEEP) || (state == S_FIN)))
    else $error("bin store written outside sweep or write back");

  a_fin_hands_over: assert property (@(posedge clk) disable iff (rst)
    fin_go |=> (out_valid && (state == S_IDLE)))
    else $error("result not handed to output register");

endmodule

`default_nettype wire

// ===== rtl/chwd_bin_ram.sv =====
// per-bin count store, one write port and one read port
// registered read data; uses chwd_pkg
`default_nettype none

module chwd_bin_ram (
  input  wire logic                      clk,
  input  wire logic                      we,
  input  wire logic [chwd_pkg::IDX_W-1:0] waddr,
  input  wire logic [chwd_pkg::CNT_W-1:0] wdata,
  input  wire logic [chwd_pkg::IDX_W-1:0] raddr,
  output logic      [chwd_pkg::CNT_W-1:0] rdata
);

  logic [chwd_pkg::CNT_W-1:0] bin_mem [chwd_pkg::NUM_BINS];

  always_ff @(posedge clk) begin
    if (we) begin
      bin_mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= bin_mem[raddr];
  end

endmodule

`default_nettype wire

// ===== rtl/chwd_mod_unit.sv =====
// iterative remainder unit, one dividend bit per cycle (restoring)
// takes a mod_req_t from chwd_pkg, pulses done with the remainder
`default_nettype none

module chwd_mod_unit (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire chwd_pkg::mod_req_t          req,
  output logic                            done,
  output logic      [chwd_pkg::TOT_W-1:0] rem
);

  logic                            busy;
  logic [chwd_pkg::STEP_W-1:0]     step;
  logic [chwd_pkg::RND_W-1:0]      shift;
  logic [chwd_pkg::TOT_W-1:0]      divisor;
  logic [chwd_pkg::TOT_W:0]        trial;
  logic [chwd_pkg::TOT_W:0]        rem_next;

  // shift in the next dividend bit, subtract if it fits
  always_comb begin
    trial = {rem, shift[chwd_pkg::RND_W-1]};
    if (trial >= {1'b0, divisor}) begin
      rem_next = trial - {1'b0, divisor};
    end else begin
      rem_next = trial;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        step <= '0;
      end else if (busy) begin
        step <= step + 1'b1;
        if (step == chwd_pkg::STEP_W'(chwd_pkg::RND_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      shift   <= req.dividend;
      divisor <= req.divisor;
      rem     <= '0;
    end else if (busy) begin
      shift <= {shift[chwd_pkg::RND_W-2:0], 1'b0};
      rem   <= rem_next[chwd_pkg::TOT_W-1:0];
    end
  end

endmodule

`default_nettype wire
